FILE: hdl/dqcs_pkg.sv
// ----------------------------------------------------------------------------
// dqcs_pkg
// Shared types, widths and codes for the deque with count and sum.
// ----------------------------------------------------------------------------
`default_nettype none

package dqcs_pkg;

  // default ring depth
  localparam int DEPTH_DEF = 256;

  // payload widths
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;
  localparam int SUM_W   = 40;
  localparam int REQ_W   = 2;
  localparam int ERR_W   = 2;

  typedef logic [REQ_W-1:0]          req_t;
  typedef logic [ERR_W-1:0]          err_t;
  typedef logic [COUNT_W-1:0]        count_out_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // request codes
  localparam req_t REQ_PUSH_FRONT = 2'd0;
  localparam req_t REQ_PUSH_BACK  = 2'd1;
  localparam req_t REQ_POP_FRONT  = 2'd2;
  localparam req_t REQ_POP_BACK   = 2'd3;

  // error codes
  localparam err_t ERR_NONE  = 2'd0;
  localparam err_t ERR_EMPTY = 2'd1;
  localparam err_t ERR_FULL  = 2'd2;

  // sign extend a stored value to the running sum width
  function automatic sum_t sext_value(input value_t v);
    sext_value = {{(SUM_W - VALUE_W){v[VALUE_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/dqcs_ram.sv
// ----------------------------------------------------------------------------
// dqcs_ram
// Simple dual port RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/deque_with_count_and_sum_top.sv
// push or failed pop: result registered in the cycle after the request
// successful pop: slot read to ram output register, result registered in S_POP
// in S_POP no new request is taken, since the slot ram read is registered
// a new request is taken once the previous result has been taken or is leaving
// reset: queue empty, head at slot 0, sum zero; slot contents are not cleared
// ----------------------------------------------------------------------------
// deque_with_count_and_sum_top
// Double-ended queue in a ring buffer with element count and running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_count_and_sum_top #(
  parameter int DEPTH = dqcs_pkg::DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dqcs_pkg::req_t      in_req_type,
  input  wire dqcs_pkg::value_t    in_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dqcs_pkg::count_out_t     out_element_count,
  output dqcs_pkg::sum_t           out_value_sum,
  output dqcs_pkg::err_t           out_error
);

  import dqcs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic            state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  sum_t            sum_r, sum_nxt;

  logic            out_valid_r, out_valid_nxt;
  count_out_t      out_count_r, out_count_nxt;
  sum_t            out_sum_r, out_sum_nxt;
  err_t            out_err_r, out_err_nxt;

  logic            accept;
  logic            out_free;
  logic            is_full;
  logic            is_empty;
  logic [SW-1:0]   tail_sum;
  logic [SW-1:0]   last_sum;
  logic [AW-1:0]   tail_pos;
  logic [AW-1:0]   last_pos;
  logic [AW-1:0]   head_dec;
  logic [AW-1:0]   head_inc;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // ring positions, all below twice the depth so one subtract wraps them
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign last_sum = tail_sum - SW'(1);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : tail_sum[AW-1:0];
  assign last_pos = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : last_sum[AW-1:0];
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // request decode and result update
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_pos;
    ram_re        = 1'b0;
    ram_raddr     = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_count_nxt = COUNT_W'(count_r);
                out_sum_nxt   = sum_r;
                out_err_nxt   = ERR_FULL;
              end else begin
                ram_we = 1'b1;
                if (in_req_type == REQ_PUSH_FRONT) begin
                  ram_waddr = head_dec;
                  head_nxt  = head_dec;
                end
                count_nxt     = count_r + CW'(1);
                sum_nxt       = sum_r + sext_value(in_value);
                out_count_nxt = COUNT_W'(count_r + CW'(1));
                out_sum_nxt   = sum_r + sext_value(in_value);
                out_err_nxt   = ERR_NONE;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (is_empty) begin
                out_valid_nxt = 1'b1;
                out_count_nxt = COUNT_W'(count_r);
                out_sum_nxt   = sum_r;
                out_err_nxt   = ERR_EMPTY;
              end else begin
                // read the removed slot, finish the sum in S_POP
                ram_re = 1'b1;
                if (in_req_type == REQ_POP_FRONT) begin
                  ram_raddr = head_r;
                  head_nxt  = head_inc;
                end else begin
                  ram_raddr = last_pos;
                end
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_POP: begin
        // slot data is held in the ram output register until the result slot frees
        if (out_free) begin
          sum_nxt       = sum_r - sext_value(ram_rdata);
          out_valid_nxt = 1'b1;
          out_count_nxt = COUNT_W'(count_r);
          out_sum_nxt   = sum_r - sext_value(ram_rdata);
          out_err_nxt   = ERR_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
    out_sum_r   <= out_sum_nxt;
    out_err_r   <= out_err_nxt;
  end

  // slot storage
  dqcs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_element_count = out_count_r;
  assign out_value_sum     = out_sum_r;
  assign out_error         = out_err_r;

endmodule

`default_nettype wire
